[hdl/asc_pkg.sv]
// Shared types, codes and sizes for the accumulator stack machine block.
package asc_pkg;

    // Data memory size in words (a power of two) and its address width
    localparam int MEM_WORDS = 65536;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    // Highest opcode with a defined meaning
    localparam logic [7:0] OPC_LAST = 8'd18;

    // Reset value of the stack limit register
    localparam logic [30:0] STACK_LIMIT_RESET = 31'd8388608;

    // Configuration register indexes
    localparam logic [1:0] CFG_PROGRAM_LENGTH = 2'd0;
    localparam logic [1:0] CFG_STACK_LIMIT    = 2'd1;

    typedef enum logic [4:0] {
        OP_LDC    = 5'd0,
        OP_ADC    = 5'd1,
        OP_LDL    = 5'd2,
        OP_STL    = 5'd3,
        OP_LDNL   = 5'd4,
        OP_STNL   = 5'd5,
        OP_ADD    = 5'd6,
        OP_SUB    = 5'd7,
        OP_SHL    = 5'd8,
        OP_SHR    = 5'd9,
        OP_ADJ    = 5'd10,
        OP_A2SP   = 5'd11,
        OP_SP2A   = 5'd12,
        OP_CALL   = 5'd13,
        OP_RETURN = 5'd14,
        OP_BRZ    = 5'd15,
        OP_BRLZ   = 5'd16,
        OP_BR     = 5'd17,
        OP_HALT   = 5'd18,
        OP_NOP    = 5'd19
    } opcode_t;

    typedef enum logic [2:0] {
        ST_EXECUTED = 3'd0,
        ST_HALTED   = 3'd1,
        ST_PC_PAST  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_STORED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_LOAD
    } back_state_t;

    // Decoded request as it travels from the front to the back
    typedef struct packed {
        logic              is_store;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       word;
        opcode_t           opc;
        logic [31:0]       opnd;
    } instr_t;

    // Machine state reported for one request
    typedef struct packed {
        logic [31:0] acc_a;
        logic [31:0] acc_b;
        logic [31:0] prog_counter;
        logic [31:0] stack_ptr;
        logic [31:0] executed_count;
        status_t     status;
    } result_t;

endpackage

[hdl/asc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module asc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read on the same edge; a read of the word being written returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/asc_front.sv]
// Front end: accept requests, decode them and hold them in a two-entry queue.
module asc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic           op,
    input  logic [15:0]    addr,
    input  logic [31:0]    word,
    input  logic           clearing,
    output logic           head_valid,
    output asc_pkg::instr_t head,
    input  logic           head_pop
);

    asc_pkg::instr_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    asc_pkg::instr_t dec;
    logic [31:0]     addr_ext;
    logic            take;
    logic            drop;

    // Decode the incoming request
    always_comb
    begin
        addr_ext     = {16'b0, addr};
        dec.is_store = ~op;
        dec.addr     = addr_ext[asc_pkg::MEM_AW-1:0];
        dec.word     = word;
        dec.opnd     = {{8{word[31]}}, word[31:8]};
        if (word[7:0] <= asc_pkg::OPC_LAST)
        begin
            dec.opc = asc_pkg::opcode_t'(word[4:0]);
        end
        else
        begin
            dec.opc = asc_pkg::OP_NOP;
        end
    end

    assign full       = (count_reg == 2'd2) | clearing;
    assign take       = push & ~full;
    assign head_valid = (count_reg != 2'd0);
    assign drop       = head_pop & head_valid;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (take & ~drop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (~take & drop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (drop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Hold decoded requests
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[hdl/asc_outq.sv]
// Result queue: two entries between the execute unit and the result ports.
module asc_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_push,
    input  asc_pkg::result_t in_data,
    output logic             in_full,
    output logic             empty,
    input  logic             pop,
    output asc_pkg::result_t head
);

    asc_pkg::result_t entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             take;
    logic             drop;

    assign in_full = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign take    = in_push & ~in_full;
    assign drop    = pop & ~empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (take & ~drop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (~take & drop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (drop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Hold results
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[hdl/asc_back.sv]
// Back end: machine registers, data memory, clearing pass and instruction execution.
module asc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [30:0]      cfg_data,
    input  logic             head_valid,
    input  asc_pkg::instr_t  head,
    output logic             head_pop,
    output logic             clearing,
    input  logic             res_full,
    output logic             res_push,
    output asc_pkg::result_t res_data
);

    localparam int AW = asc_pkg::MEM_AW;

    asc_pkg::back_state_t state_reg;
    asc_pkg::back_state_t state_next;
    logic [AW-1:0]        clr_cnt_reg;
    logic [24:0]          prog_len_reg;
    logic [30:0]          stack_limit_reg;
    logic [31:0]          a_reg;
    logic [31:0]          b_reg;
    logic [31:0]          pc_reg;
    logic [31:0]          sp_reg;
    logic [31:0]          count_reg;
    logic                 ovf_reg;

    logic [31:0]          a_next;
    logic [31:0]          b_next;
    logic [31:0]          pc_next;
    logic [31:0]          sp_next;
    logic [31:0]          count_next;
    logic                 ovf_next;
    asc_pkg::status_t     status_v;

    logic [31:0]          sum_sp;
    logic [31:0]          sum_a;
    logic                 past;
    logic                 exec_ok;
    logic                 need_load;
    logic                 finish;
    logic                 item_we;
    logic [AW-1:0]        item_waddr;
    logic [31:0]          item_wdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [31:0]          mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [31:0]          mem_rdata;
    logic [31:0]          pc_br;

    asc_ram #(
        .WIDTH (32),
        .DEPTH (asc_pkg::MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Classify the head request against the machine state
    assign sum_sp    = sp_reg + head.opnd;
    assign sum_a     = a_reg + head.opnd;
    assign past      = ~pc_reg[31] & (pc_reg >= {7'b0, prog_len_reg});
    assign exec_ok   = ~head.is_store & ~ovf_reg & ~past;
    assign need_load = exec_ok & ((head.opc == asc_pkg::OP_LDL) |
                                  (head.opc == asc_pkg::OP_LDNL));
    assign mem_raddr = (head.opc == asc_pkg::OP_LDL) ? sum_sp[AW-1:0] : sum_a[AW-1:0];
    assign clearing  = (state_reg == asc_pkg::BK_CLEAR);

    // Sequence clearing, requests that need no load, and loads
    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        case (state_reg)
            asc_pkg::BK_CLEAR:
            begin
                if (clr_cnt_reg == AW'(asc_pkg::MEM_WORDS - 1))
                begin
                    state_next = asc_pkg::BK_RUN;
                end
            end
            asc_pkg::BK_RUN:
            begin
                if (head_valid & ~res_full)
                begin
                    if (need_load)
                    begin
                        state_next = asc_pkg::BK_LOAD;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
            end
            asc_pkg::BK_LOAD:
            begin
                finish     = 1'b1;
                state_next = asc_pkg::BK_RUN;
            end
            default:
            begin
                state_next = asc_pkg::BK_RUN;
            end
        endcase
    end

    // Execute the head request
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        pc_next    = pc_reg;
        sp_next    = sp_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        status_v   = asc_pkg::ST_EXECUTED;
        item_we    = 1'b0;
        item_waddr = head.addr;
        item_wdata = head.word;
        pc_br      = pc_reg;
        if (head.is_store)
        begin
            item_we  = 1'b1;
            status_v = asc_pkg::ST_STORED;
        end
        else if (ovf_reg)
        begin
            status_v = asc_pkg::ST_OVERFLOW;
        end
        else if (past)
        begin
            status_v = asc_pkg::ST_PC_PAST;
        end
        else
        begin
            count_next = count_reg + 32'd1;
            if (head.opc == asc_pkg::OP_HALT)
            begin
                status_v = asc_pkg::ST_HALTED;
            end
            else
            begin
                case (head.opc)
                    asc_pkg::OP_LDC:
                    begin
                        b_next = a_reg;
                        a_next = head.opnd;
                    end
                    asc_pkg::OP_ADC:  a_next = sum_a;
                    asc_pkg::OP_LDL:
                    begin
                        b_next = a_reg;
                        a_next = mem_rdata;
                    end
                    asc_pkg::OP_STL:
                    begin
                        item_we    = 1'b1;
                        item_waddr = sum_sp[AW-1:0];
                        item_wdata = a_reg;
                        a_next     = b_reg;
                    end
                    asc_pkg::OP_LDNL: a_next = mem_rdata;
                    asc_pkg::OP_STNL:
                    begin
                        item_we    = 1'b1;
                        item_waddr = sum_a[AW-1:0];
                        item_wdata = b_reg;
                    end
                    asc_pkg::OP_ADD:  a_next = b_reg + a_reg;
                    asc_pkg::OP_SUB:  a_next = b_reg - a_reg;
                    asc_pkg::OP_SHL:  a_next = b_reg << a_reg[4:0];
                    asc_pkg::OP_SHR:  a_next = $unsigned($signed(b_reg) >>> a_reg[4:0]);
                    asc_pkg::OP_ADJ:  sp_next = sum_sp;
                    asc_pkg::OP_A2SP:
                    begin
                        sp_next = a_reg;
                        a_next  = b_reg;
                    end
                    asc_pkg::OP_SP2A:
                    begin
                        b_next = a_reg;
                        a_next = sp_reg;
                    end
                    asc_pkg::OP_CALL:
                    begin
                        a_next = pc_reg;
                        b_next = a_reg;
                        pc_br  = head.opnd - 32'd1;
                    end
                    asc_pkg::OP_RETURN:
                    begin
                        pc_br  = a_reg;
                        a_next = b_reg;
                    end
                    asc_pkg::OP_BRZ:
                    begin
                        if (a_reg == 32'd0)
                        begin
                            pc_br = pc_reg + head.opnd;
                        end
                    end
                    asc_pkg::OP_BRLZ:
                    begin
                        if (a_reg[31])
                        begin
                            pc_br = pc_reg + head.opnd;
                        end
                    end
                    asc_pkg::OP_BR:   pc_br = pc_reg + head.opnd;
                    default:
                    begin
                    end
                endcase
                pc_next = pc_br + 32'd1;
                // Flag stack overflow and make it sticky
                if (~sp_next[31] & (sp_next[30:0] > stack_limit_reg))
                begin
                    ovf_next = 1'b1;
                    status_v = asc_pkg::ST_OVERFLOW;
                end
            end
        end
    end

    // Select the memory write: clearing sweep or the finishing request
    always_comb
    begin
        if (state_reg == asc_pkg::BK_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 32'd0;
        end
        else
        begin
            mem_we    = finish & item_we;
            mem_waddr = item_waddr;
            mem_wdata = item_wdata;
        end
    end

    assign head_pop = finish;
    assign res_push = finish;

    always_comb
    begin
        res_data.acc_a          = a_next;
        res_data.acc_b          = b_next;
        res_data.prog_counter   = pc_next;
        res_data.stack_ptr      = sp_next;
        res_data.executed_count = count_next;
        res_data.status         = status_v;
    end

    // Update state, configuration and machine registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= asc_pkg::BK_CLEAR;
            clr_cnt_reg     <= '0;
            prog_len_reg    <= 25'd0;
            stack_limit_reg <= asc_pkg::STACK_LIMIT_RESET;
            a_reg           <= 32'd0;
            b_reg           <= 32'd0;
            pc_reg          <= 32'd0;
            sp_reg          <= 32'd0;
            count_reg       <= 32'd0;
            ovf_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == asc_pkg::BK_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg_write)
            begin
                if (cfg_index == asc_pkg::CFG_PROGRAM_LENGTH)
                begin
                    prog_len_reg <= cfg_data[24:0];
                end
                else if (cfg_index == asc_pkg::CFG_STACK_LIMIT)
                begin
                    stack_limit_reg <= cfg_data;
                end
            end
            if (finish)
            begin
                a_reg     <= a_next;
                b_reg     <= b_next;
                pc_reg    <= pc_next;
                sp_reg    <= sp_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

[hdl/accumulator_stack_cpu_step.sv]
// Top level of the two-register stack machine: front decode, execute unit, result queue.
//
//  channel   handshake         payload
//  -------   ---------------   --------------------------------------------------
//  request   push / full       op, addr, word
//  result    empty / pop       acc_a, acc_b, prog_counter, stack_ptr,
//                              executed_count, status
//  config    cfg_write         cfg_index, cfg_data
//
// Stores and most instructions finish in the run state of the execute unit; ldl and ldnl
// also pass through a load state, for the registered read port of the data memory.
// After reset a clearing pass zeroes the data memory, one word a cycle over all MEM_WORDS
// words; full stays high during it while configuration writes are taken.
// Two-entry queues before and after the execute unit let requests and results stall
// independently.
module accumulator_stack_cpu_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        op,
    input  logic [15:0] addr,
    input  logic signed [31:0] word,
    output logic        empty,
    input  logic        pop,
    output logic signed [31:0] acc_a,
    output logic signed [31:0] acc_b,
    output logic signed [31:0] prog_counter,
    output logic signed [31:0] stack_ptr,
    output logic [31:0] executed_count,
    output logic [2:0]  status,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    asc_pkg::instr_t  head;
    logic             head_valid;
    logic             head_pop;
    logic             clearing;
    logic             res_full;
    logic             res_push;
    asc_pkg::result_t res_data;
    asc_pkg::result_t res_head;

    asc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .addr       (addr),
        .word       (word),
        .clearing   (clearing),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    asc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .clearing   (clearing),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    asc_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_push (res_push),
        .in_data (res_data),
        .in_full (res_full),
        .empty   (empty),
        .pop     (pop),
        .head    (res_head)
    );

    // Drive result ports from the oldest waiting result
    assign acc_a          = res_head.acc_a;
    assign acc_b          = res_head.acc_b;
    assign prog_counter   = res_head.prog_counter;
    assign stack_ptr      = res_head.stack_ptr;
    assign executed_count = res_head.executed_count;
    assign status         = res_head.status;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-register stack machine: directed and random requests.
module tb_top;
    import asc_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          IDLE_DRAIN  = 4;
    localparam int          END_DRAIN   = 16;
    localparam int          CHUNKS      = 15;
    localparam int          CHUNK_ITEMS = 37;
    localparam bit          REQ_STORE   = 1'b0;
    localparam bit          REQ_EXEC    = 1'b1;
    localparam logic [24:0] PLEN_MAX    = 25'd16777216;
    localparam logic [30:0] LIMIT_MAX   = 31'h7FFFFFFF;
    localparam logic [7:0]  OPC_TOP     = 8'hFF;
    localparam logic [23:0] OPND_MIN    = 24'h800000;
    localparam logic [23:0] OPND_MAX    = 24'h7FFFFF;
    localparam logic [31:0] PC_SAFE     = 32'h00800000;

    // DUT ports
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        op = 1'b0;
    logic [15:0] addr = '0;
    logic [31:0] word = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] acc_a;
    logic [31:0] acc_b;
    logic [31:0] prog_counter;
    logic [31:0] stack_ptr;
    logic [31:0] executed_count;
    logic [2:0]  status;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    // Machine copy kept by the testbench
    logic [24:0] m_prog_len;
    logic [30:0] m_limit;
    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [31:0] m_pc;
    logic [31:0] m_sp;
    logic [31:0] m_count;
    logic        m_overflow;
    logic [31:0] data_mem [MEM_WORDS];

    result_t pending_states[$];
    bit      failed = 1'b0;
    bit      idle_on = 1'b1;
    int      pop_stall = 0;
    int      cycle_count = 0;

    accumulator_stack_cpu_step DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .addr           (addr),
        .word           (word),
        .empty          (empty),
        .pop            (pop),
        .acc_a          (acc_a),
        .acc_b          (acc_b),
        .prog_counter   (prog_counter),
        .stack_ptr      (stack_ptr),
        .executed_count (executed_count),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic logic [31:0] instr(logic [7:0] opc, logic [23:0] opnd);
        return {opnd, opc};
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1'b1;
        end
    endfunction

    // Advance the machine copy by one accepted request and queue the state it reports
    task automatic step_machine(input bit is_exec, input logic [15:0] a,
                                input logic [31:0] w);
        logic [7:0]  opc;
        logic [31:0] opnd;
        logic [31:0] tmp;
        result_t     res;
        opc  = w[7:0];
        opnd = {{8{w[31]}}, w[31:8]};
        if (!is_exec)
        begin
            data_mem[a] = w;
            res.status = ST_STORED;
        end
        else if (m_overflow)
        begin
            res.status = ST_OVERFLOW;
        end
        else if (!m_pc[31] && m_pc >= {7'd0, m_prog_len})
        begin
            res.status = ST_PC_PAST;
        end
        else
        begin
            m_count = m_count + 1;
            if (opc == OPC_LAST)
            begin
                res.status = ST_HALTED;
            end
            else
            begin
                // opcodes past halt do nothing but advance the PC and the executed count
                if (opc < OPC_LAST)
                begin
                    case (opcode_t'(opc[4:0]))
                        OP_LDC:
                        begin
                            m_b = m_a;
                            m_a = opnd;
                        end
                        OP_ADC:  m_a = m_a + opnd;
                        OP_LDL:
                        begin
                            tmp = m_sp + opnd;
                            m_b = m_a;
                            m_a = data_mem[tmp[MEM_AW-1:0]];
                        end
                        OP_STL:
                        begin
                            tmp = m_sp + opnd;
                            data_mem[tmp[MEM_AW-1:0]] = m_a;
                            m_a = m_b;
                        end
                        OP_LDNL:
                        begin
                            tmp = m_a + opnd;
                            m_a = data_mem[tmp[MEM_AW-1:0]];
                        end
                        OP_STNL:
                        begin
                            tmp = m_a + opnd;
                            data_mem[tmp[MEM_AW-1:0]] = m_b;
                        end
                        OP_ADD:  m_a = m_b + m_a;
                        OP_SUB:  m_a = m_b - m_a;
                        OP_SHL:  m_a = m_b << m_a[4:0];
                        OP_SHR:  m_a = $signed(m_b) >>> m_a[4:0];
                        OP_ADJ:  m_sp = m_sp + opnd;
                        OP_A2SP:
                        begin
                            m_sp = m_a;
                            m_a = m_b;
                        end
                        OP_SP2A:
                        begin
                            m_b = m_a;
                            m_a = m_sp;
                        end
                        OP_CALL:
                        begin
                            m_b = m_a;
                            m_a = m_pc;
                            m_pc = opnd - 1;
                        end
                        OP_RETURN:
                        begin
                            m_pc = m_a;
                            m_a = m_b;
                        end
                        OP_BRZ:  if (m_a == '0) m_pc = m_pc + opnd;
                        OP_BRLZ: if (m_a[31]) m_pc = m_pc + opnd;
                        OP_BR:   m_pc = m_pc + opnd;
                        default: ;
                    endcase
                end
                m_pc = m_pc + 1;
                res.status = ST_EXECUTED;
                if (!m_sp[31] && m_sp > {1'b0, m_limit})
                begin
                    m_overflow = 1'b1;
                    res.status = ST_OVERFLOW;
                end
            end
        end
        res.acc_a          = m_a;
        res.acc_b          = m_b;
        res.prog_counter   = m_pc;
        res.stack_ptr      = m_sp;
        res.executed_count = m_count;
        pending_states = {pending_states, res};
    endtask

    // Drive one request, hold it until taken, then predict it
    task automatic send_request(input bit is_exec, input logic [15:0] a,
                                input logic [31:0] w);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        op   <= is_exec;
        addr <= a;
        word <= w;
        @(posedge clk);
        while (full) @(posedge clk);
        step_machine(is_exec, a, w);
    endtask

    task automatic run_op(input logic [7:0] opc, input logic [23:0] opnd);
        send_request(REQ_EXEC, 16'($urandom), instr(opc, opnd));
    endtask

    // Drop push and let every pending result come back
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_states.size() != 0) @(posedge clk);
        repeat (IDLE_DRAIN) @(posedge clk);
    endtask

    task automatic set_config(input logic [24:0] plen, input logic [30:0] limit);
        cfg_write <= 1'b1;
        cfg_index <= CFG_PROGRAM_LENGTH;
        cfg_data  <= 31'(plen);
        @(posedge clk);
        cfg_index <= CFG_STACK_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_write <= 1'b0;
        m_prog_len = plen;
        m_limit    = limit;
    endtask

    // Bring the PC back to a small value under the widest program window
    task automatic recenter(input logic [23:0] target);
        wait_idle();
        set_config(PLEN_MAX, LIMIT_MAX);
        run_op(8'(OP_CALL), target);
    endtask

    // Pop results with random stall bursts and compare each against the oldest prediction
    always @(posedge clk)
    begin : collect_results
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_states.size() == 0)
            begin
                $error("result arrived with no request pending");
                failed = 1'b1;
            end
            else
            begin
                want = pending_states.pop_front();
                check_field("acc_a", want.acc_a, acc_a);
                check_field("acc_b", want.acc_b, acc_b);
                check_field("prog_counter", want.prog_counter, prog_counter);
                check_field("stack_ptr", want.stack_ptr, stack_ptr);
                check_field("executed_count", want.executed_count, executed_count);
                check_field("status", 32'(want.status), 32'(status));
            end
        end
        if (pop_stall > 0)
            pop_stall = pop_stall - 1;
        else if (idle_on && $urandom_range(0, 5) == 0)
            pop_stall = $urandom_range(1, 4);
        pop <= (pop_stall == 0);
    end

    // Requests taken while the program window is still empty after reset
    task automatic test_reset_state();
        run_op(8'(OP_LDC), 24'd1);
        run_op(OPC_LAST, '0);
        send_request(REQ_STORE, 16'hFFFF, 32'h7FFFFFFF);
        run_op(OPC_TOP, 24'hFFFFFF);
        wait_idle();
    endtask

    task automatic test_alu_and_memory();
        set_config(PLEN_MAX, LIMIT_MAX);
        send_request(REQ_STORE, 16'h0000, 32'h80000000);
        run_op(8'(OP_LDC), OPND_MIN);
        run_op(8'(OP_LDC), OPND_MAX);
        run_op(8'(OP_ADC), 24'd1);
        run_op(8'(OP_ADD), '0);
        run_op(8'(OP_SUB), '0);
        run_op(8'(OP_LDC), 24'(-3));
        run_op(8'(OP_LDC), 24'd33);
        run_op(8'(OP_SHL), '0);
        run_op(8'(OP_LDC), 24'd31);
        run_op(8'(OP_SHR), '0);
        run_op(8'(OP_STL), 24'd5);
        run_op(8'(OP_LDL), 24'd5);
        run_op(8'(OP_LDC), '0);
        run_op(8'(OP_LDNL), '0);
        run_op(8'(OP_STNL), 24'(-1));
        run_op(8'(OP_LDNL), 24'(-1));
    endtask

    task automatic test_control_flow();
        run_op(8'(OP_ADJ), 24'(-1));
        run_op(8'(OP_SP2A), '0);
        run_op(8'(OP_A2SP), '0);
        run_op(8'(OP_CALL), 24'd3);
        run_op(8'(OP_RETURN), '0);
        run_op(8'(OP_LDC), '0);
        run_op(8'(OP_BRZ), 24'd2);
        run_op(8'(OP_LDC), 24'(-1));
        run_op(8'(OP_BRLZ), 24'(-2));
        run_op(8'(OP_BR), 24'd1);
        run_op(OPC_LAST, '0);
        run_op(8'(OP_NOP), 24'd7);
        run_op(OPC_TOP, OPND_MIN);
    endtask

    // A negative stack pointer never counts as over the limit, even a zero limit
    task automatic test_negative_stack();
        run_op(8'(OP_LDC), 24'(-5));
        run_op(8'(OP_A2SP), '0);
        wait_idle();
        set_config(PLEN_MAX, '0);
        run_op(8'(OP_LDC), 24'd1);
        run_op(8'(OP_ADC), 24'd2);
    endtask

    // Run off the end of a short program, then run with a negative PC under an empty window
    task automatic test_program_window();
        recenter('0);
        wait_idle();
        set_config(25'd2, LIMIT_MAX);
        run_op(8'(OP_LDC), 24'd1);
        run_op(8'(OP_LDC), 24'd2);
        run_op(8'(OP_LDC), 24'd3);
        send_request(REQ_STORE, 16'h1234, 32'h5A5A5A5A);
        run_op(OPC_LAST, '0);
        wait_idle();
        set_config(PLEN_MAX, LIMIT_MAX);
        run_op(8'(OP_BR), 24'(-100));
        wait_idle();
        set_config('0, LIMIT_MAX);
        run_op(8'(OP_LDC), 24'd4);
        run_op(OPC_LAST, '0);
    endtask

    // One random request, steered so the PC stays inside the widest window
    task automatic send_random_item();
        logic [7:0]  opc;
        logic [23:0] opnd;
        logic [15:0] a;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            // aim half the stores near the stack so loads see them
            a = (pick < 8) ? 16'(m_sp + 32'($urandom_range(0, 15))) : 16'($urandom);
            send_request(REQ_STORE, a, $urandom);
        end
        else
        begin
            if ($urandom_range(0, 99) < 88)
                opc = 8'($urandom_range(0, OPC_LAST));
            else
                opc = 8'($urandom_range(OPC_LAST + 1, OPC_TOP));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: opnd = 24'($urandom_range(0, 32)) - 24'd16;
                5, 6, 7:       opnd = 24'($urandom);
                8:             opnd = OPND_MIN;
                default:       opnd = OPND_MAX;
            endcase
            if ((!m_pc[31] && m_pc >= PC_SAFE) ||
                (opc == 8'(OP_RETURN) && !m_a[31] && m_a >= PC_SAFE))
            begin
                opc  = 8'(OP_CALL);
                opnd = 24'($urandom_range(0, 64));
            end
            run_op(opc, opnd);
        end
    endtask

    task automatic test_random_programs();
        int          kind;
        logic [24:0] plen;
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            idle_on = (chunk < CHUNKS - 3) && (chunk % 5 != 2);
            recenter(24'($urandom_range(0, 8)));
            kind = $urandom_range(0, 9);
            if (kind < 6)
                plen = PLEN_MAX;
            else if (kind < 8)
                plen = 25'(m_pc) + 25'($urandom_range(0, 40));
            else if (kind == 8)
                plen = 25'($urandom_range(0, PLEN_MAX));
            else
                plen = '0;
            wait_idle();
            set_config(plen, LIMIT_MAX);
            repeat (CHUNK_ITEMS) send_random_item();
        end
    endtask

    // Stack exactly at the limit passes, one word more trips the sticky overflow
    task automatic test_stack_overflow();
        idle_on = 1'b0;
        recenter('0);
        run_op(8'(OP_LDC), '0);
        run_op(8'(OP_A2SP), '0);
        wait_idle();
        set_config(PLEN_MAX, STACK_LIMIT_RESET);
        run_op(8'(OP_LDC), OPND_MAX);
        run_op(8'(OP_ADC), 24'd1);
        run_op(8'(OP_A2SP), '0);
        run_op(8'(OP_ADJ), 24'd1);
        run_op(8'(OP_LDC), 24'd9);
        run_op(OPC_LAST, '0);
        send_request(REQ_STORE, 16'h0040, 32'hCAFE0001);
        run_op(8'(OP_LDL), 24'd0);
        repeat (20) send_random_item();
    endtask

    initial
    begin
        m_prog_len = '0;
        m_limit    = STACK_LIMIT_RESET;
        m_a        = '0;
        m_b        = '0;
        m_pc       = '0;
        m_sp       = '0;
        m_count    = '0;
        m_overflow = 1'b0;
        for (int i = 0; i < MEM_WORDS; i++)
            data_mem[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_alu_and_memory();
        test_control_flow();
        test_negative_stack();
        test_program_window();
        test_random_programs();
        test_stack_overflow();

        wait_idle();
        repeat (END_DRAIN) @(posedge clk);
        if (!failed && pending_states.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[accumulator_stack_cpu_step.f]
hdl/asc_pkg.sv
hdl/asc_ram.sv
hdl/asc_front.sv
hdl/asc_outq.sv
hdl/asc_back.sv
hdl/accumulator_stack_cpu_step.sv
verif/tb_top.sv
